[rtl/dstq_pkg.sv]
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and constants for the deadline-sorted task queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int YEAR_W     = 14;
  localparam int FIELD_W    = 7;
  localparam int KEY_W      = YEAR_W + 4 * FIELD_W;
  localparam int TAG_PORT_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;    // capture transaction fields
    logic    ins;     // sorted insert of captured key/tag
    logic    rem;     // delete entry at captured rank
    logic    rd;      // read entry at captured rank into result
    logic    emit;    // register result payload
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rank_ok;
    logic full;
  } dp_stat_t;

endpackage

[rtl/deadline_sorted_task_queue.sv]
// Sequencing: accept in idle, then execute, then reinsert for update, which
//   removes and then reinserts; out_valid is registered from the last state.
// A new transaction is held off by busy until the sequencer is back in idle,
//   so the block does not take one before it is through with the last.
// Reset (rst_n low, synchronous): entry count zero, sequencer idle, no strobe.
// Results cannot be held off; out_valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
// deadline_sorted_task_queue
// Bounded table of deadline-keyed entries kept in ascending key order, with
// insert, remove, update and read by 1-based rank.
// ----------------------------------------------------------------------------
module deadline_sorted_task_queue #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel: a transaction is taken when start && !busy
  input  logic                            start,
  output logic                            busy,
  input  logic [dstq_pkg::MODE_W-1:0]     in_mode,
  input  logic [CNT_W-1:0]                in_rank,
  input  logic [dstq_pkg::YEAR_W-1:0]     in_due_year,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_month,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_day,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_hour,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_minute,
  input  logic [dstq_pkg::TAG_PORT_W-1:0] in_tag,
  // result channel: one cycle per transaction, marked by out_valid
  output logic                            out_valid,
  output logic [dstq_pkg::STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]                out_entry_count,
  output logic [dstq_pkg::YEAR_W-1:0]     out_read_year,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_month,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_day,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_hour,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_minute,
  output logic [dstq_pkg::TAG_PORT_W-1:0] out_read_tag
);
  import dstq_pkg::*;

  // Command / status between sequencer and cell array.
  // The sequencer latches the mode on accept, checks rank and fullness in
  // the execute cycle, and for update issues remove then insert on
  // consecutive cycles so the insert compares against the compacted table.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dstq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Cell array: every cell compares the new key at once, then the array
  // shifts by one to open (insert) or close (remove) a slot.
  dstq_datapath #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_rank         (in_rank),
    .in_due_year     (in_due_year),
    .in_due_month    (in_due_month),
    .in_due_day      (in_due_day),
    .in_due_hour     (in_due_hour),
    .in_due_minute   (in_due_minute),
    .in_tag          (in_tag),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_year   (out_read_year),
    .out_read_month  (out_read_month),
    .out_read_day    (out_read_day),
    .out_read_hour   (out_read_hour),
    .out_read_minute (out_read_minute),
    .out_read_tag    (out_read_tag)
  );

endmodule

[rtl/dstq_ctrl.sv]
// ----------------------------------------------------------------------------
// dstq_ctrl
// Sequencer: decodes the transaction mode and steps the cell array.
// ----------------------------------------------------------------------------
module dstq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dstq_pkg::MODE_W-1:0]  in_mode,
  input  dstq_pkg::dp_stat_t           stat,
  output logic                         busy,
  output logic                         out_valid,
  output dstq_pkg::dp_cmd_t            cmd
);
  import dstq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS
  } state_t;

  state_t  state_r, state_nxt;
  mode_t   mode_r;
  logic    out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        cmd.emit  = 1'b1;
        case (mode_r)
          MODE_INSERT: begin
            if (stat.full) cmd.status = STAT_FULL;
            else           cmd.ins    = 1'b1;
          end
          MODE_REMOVE: begin
            if (!stat.rank_ok) cmd.status = STAT_NOT_FOUND;
            else               cmd.rem    = 1'b1;
          end
          MODE_UPDATE: begin
            if (!stat.rank_ok) begin
              cmd.status = STAT_NOT_FOUND;
            end else begin
              cmd.rem   = 1'b1;
              cmd.emit  = 1'b0;
              state_nxt = S_REINS;
            end
          end
          MODE_READ: begin
            if (!stat.rank_ok) cmd.status = STAT_NOT_FOUND;
            else               cmd.rd     = 1'b1;
          end
          default: cmd.status = STAT_NOT_FOUND;
        endcase
      end
      S_REINS: begin
        // removal left room, so the reinsert always succeeds
        cmd.ins   = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_INSERT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
      if (cmd.load) mode_r <= mode_t'(in_mode);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/dstq_datapath.sv]
// ----------------------------------------------------------------------------
// dstq_datapath
// Sorted cell array with parallel key compare, shift and result registers.
// ----------------------------------------------------------------------------
module dstq_datapath #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int IDX_W   = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dstq_pkg::dp_cmd_t               cmd,
  output dstq_pkg::dp_stat_t              stat,
  input  logic [CNT_W-1:0]                in_rank,
  input  logic [dstq_pkg::YEAR_W-1:0]     in_due_year,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_month,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_day,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_hour,
  input  logic [dstq_pkg::FIELD_W-1:0]    in_due_minute,
  input  logic [dstq_pkg::TAG_PORT_W-1:0] in_tag,
  output logic [dstq_pkg::STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]                out_entry_count,
  output logic [dstq_pkg::YEAR_W-1:0]     out_read_year,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_month,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_day,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_hour,
  output logic [dstq_pkg::FIELD_W-1:0]    out_read_minute,
  output logic [dstq_pkg::TAG_PORT_W-1:0] out_read_tag
);
  import dstq_pkg::*;

  // only bits that fit both the port and TAG_BITS are kept
  localparam int TW = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

  logic [KEY_W-1:0] key_r;
  logic [TW-1:0]    tag_r;
  logic [CNT_W-1:0] rank_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rank_m1;

  logic [KEY_W-1:0] cell_key_r   [DEPTH];
  logic [TW-1:0]    cell_tag_r   [DEPTH];
  logic [KEY_W-1:0] cell_key_nxt [DEPTH];
  logic [TW-1:0]    cell_tag_nxt [DEPTH];
  logic [DEPTH-1:0] moves;

  logic [KEY_W-1:0] rd_key;
  logic [TW-1:0]    rd_tag;

  logic [STATUS_W-1:0]   status_r;
  logic [CNT_W-1:0]      ocount_r;
  logic [KEY_W-1:0]      okey_r;
  logic [TAG_PORT_W-1:0] otag_r;

  assign rank_m1      = rank_r - CNT_W'(1);
  assign stat.rank_ok = (rank_r != '0) && (rank_r <= count_r);
  assign stat.full    = (count_r == CNT_W'(DEPTH));

  // Each cell: moves[i] when it holds a valid key strictly above the new one.
  // Sorted order makes moves[] a run of ones from the insert point to the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             valid, at_end, prev_moves, has_next, past_rank;
    logic [KEY_W-1:0] prev_key, next_key;
    logic [TW-1:0]    prev_tag, next_tag;

    assign valid     = (CNT_W'(i) < count_r);
    assign at_end    = (CNT_W'(i) == count_r);
    assign past_rank = (CNT_W'(i) >= rank_m1);
    assign moves[i]  = valid && (key_r < cell_key_r[i]);

    if (i == 0) begin : g_first
      assign prev_moves = 1'b0;
      assign prev_key   = key_r;
      assign prev_tag   = tag_r;
    end else begin : g_mid
      assign prev_moves = moves[i-1];
      assign prev_key   = cell_key_r[i-1];
      assign prev_tag   = cell_tag_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign has_next = 1'b0;
      assign next_key = cell_key_r[i];
      assign next_tag = cell_tag_r[i];
    end else begin : g_body
      assign has_next = 1'b1;
      assign next_key = cell_key_r[i+1];
      assign next_tag = cell_tag_r[i+1];
    end

    assign cell_key_nxt[i] =
      (cmd.ins && prev_moves)                       ? prev_key :
      (cmd.ins && (moves[i] || at_end))             ? key_r    :
      (cmd.rem && has_next && past_rank)            ? next_key :
                                                      cell_key_r[i];
    assign cell_tag_nxt[i] =
      (cmd.ins && prev_moves)                       ? prev_tag :
      (cmd.ins && (moves[i] || at_end))             ? tag_r    :
      (cmd.rem && has_next && past_rank)            ? next_tag :
                                                      cell_tag_r[i];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins)      count_nxt = count_r + CNT_W'(1);
    else if (cmd.rem) count_nxt = count_r - CNT_W'(1);
  end

  assign rd_key = cell_key_r[rank_m1[IDX_W-1:0]];
  assign rd_tag = cell_tag_r[rank_m1[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_key_r <= cell_key_nxt;
    cell_tag_r <= cell_tag_nxt;
    if (cmd.load) begin
      key_r  <= {in_due_year, in_due_month, in_due_day, in_due_hour, in_due_minute};
      tag_r  <= in_tag[TW-1:0];
      rank_r <= in_rank;
    end
    if (cmd.emit) begin
      status_r <= cmd.status;
      ocount_r <= count_nxt;
      okey_r   <= cmd.rd ? rd_key : '0;
      otag_r   <= cmd.rd ? TAG_PORT_W'(rd_tag) : '0;
    end
  end

  assign out_status      = status_r;
  assign out_entry_count = ocount_r;
  assign out_read_year   = okey_r[KEY_W-1 -: YEAR_W];
  assign out_read_month  = okey_r[4*FIELD_W-1 -: FIELD_W];
  assign out_read_day    = okey_r[3*FIELD_W-1 -: FIELD_W];
  assign out_read_hour   = okey_r[2*FIELD_W-1 -: FIELD_W];
  assign out_read_minute = okey_r[FIELD_W-1:0];
  assign out_read_tag    = otag_r;

endmodule

[rtl/dstq_checker.sv]
// ----------------------------------------------------------------------------
// dstq_checker
// Port-level timing and result checks for the task queue, bound to the top.
// ----------------------------------------------------------------------------
module dstq_checker #(
  parameter int DEPTH    = 16,
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [dstq_pkg::STATUS_W-1:0]   out_status,
  input logic [CNT_W-1:0]                out_entry_count,
  input logic [dstq_pkg::YEAR_W-1:0]     out_read_year,
  input logic [dstq_pkg::TAG_PORT_W-1:0] out_read_tag
);
  import dstq_pkg::*;

  // accepted transaction occupies the block and gives no result next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accept not followed by busy without strobe");

  // a result ends the transaction: block is free while the strobe is up
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_entry_count == CNT_W'(DEPTH)))
    else $error("full status with table not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> ((out_read_year == '0) && (out_read_tag == '0)))
    else $error("read data nonzero on failed transaction");

endmodule

bind deadline_sorted_task_queue dstq_checker #(.DEPTH(DEPTH)) u_dstq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count),
  .out_read_year   (out_read_year),
  .out_read_tag    (out_read_tag)
);
